FILE: hdl/gfn_pkg.sv
// Shared types, widths and codes of the gamut fit toward neutral block.
`timescale 1ns / 1ps
package gfn_pkg;

  localparam int PX_W = 32;
  localparam int W_W = 18;
  localparam int PROD_W = PX_W + W_W;
  localparam int Y_W = PROD_W + 2;
  localparam int V_W = PX_W + 16;
  localparam int D_W = V_W + 2;
  localparam int RW = 49;
  localparam int SCALE_FRAC = 24;
  localparam int DIV_STEPS = SCALE_FRAC;
  localparam int LO_W = 26;
  localparam int SUM_W = 76;
  localparam int ROUND_SHIFT = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE = 2'd2;

  localparam logic signed [W_W-1:0] WR_RESET = 18'sd13933;
  localparam logic signed [W_W-1:0] WG_RESET = 18'sd46871;
  localparam logic signed [W_W-1:0] WB_RESET = 18'sd4732;

  typedef enum logic [1:0] {
    PATH_KEEP  = 2'd0,
    PATH_BLACK = 2'd1,
    PATH_WHITE = 2'd2,
    PATH_SCALE = 2'd3
  } fit_path_t;

  typedef struct packed {
    logic signed [PX_W-1:0] red_in;
    logic signed [PX_W-1:0] green_in;
    logic signed [PX_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic signed [PX_W-1:0] red_out;
    logic signed [PX_W-1:0] green_out;
    logic signed [PX_W-1:0] blue_out;
    logic [1:0] fit_path;
  } pixel_out_t;

  typedef struct packed {
    logic signed [W_W-1:0] red;
    logic signed [W_W-1:0] green;
    logic signed [W_W-1:0] blue;
  } weights_t;

  typedef struct packed {
    fit_path_t path;
    logic [2:0][PX_W-1:0] clip;
    logic [Y_W-1:0] y;
    logic [2:0][D_W-1:0] d;
    logic [2:0] cand;
  } side_t;

endpackage

FILE: hdl/gfn_luma.sv
// Two-stage luminance unit: three weighted products, then their sum.
`timescale 1ns / 1ps
module gfn_luma
  import gfn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  weights_t weights,
  input  logic in_valid,
  input  pixel_in_t in_pix,
  output logic out_valid,
  output pixel_in_t out_pix,
  output logic signed [Y_W-1:0] y
);

  logic valid1;
  pixel_in_t pix1;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_g;
  logic signed [PROD_W-1:0] prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1 <= in_pix;
      prod_r <= weights.red * in_pix.red_in;
      prod_g <= weights.green * in_pix.green_in;
      prod_b <= weights.blue * in_pix.blue_in;
      out_pix <= pix1;
      y <= Y_W'(prod_r) + Y_W'(prod_g) + Y_W'(prod_b);
    end
  end

endmodule

FILE: hdl/gfn_div.sv
// Pipelined restoring divider giving one quotient bit per register stage.
`timescale 1ns / 1ps
module gfn_div
  import gfn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic [RW-1:0] num,
  input  logic [RW-1:0] den,
  output logic [SCALE_FRAC-1:0] quo
);

  logic [RW-1:0] rem_q [DIV_STEPS];
  logic [RW-1:0] den_q [DIV_STEPS];
  logic [SCALE_FRAC-1:0] quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [RW-1:0] r_in;
    logic [RW-1:0] d_in;
    logic [SCALE_FRAC-1:0] q_in;
    logic [RW-1:0] shifted;
    logic ge;
    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end
    assign shifted = {r_in[RW-2:0], 1'b0};
    assign ge = shifted >= d_in;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? shifted - d_in : shifted;
        den_q[k] <= d_in;
        quo_q[k] <= {q_in[SCALE_FRAC-2:0], ge};
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

FILE: hdl/gfn_blend.sv
// Two-stage blend toward grey: split product, then sum and round to nearest.
`timescale 1ns / 1ps
module gfn_blend
  import gfn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic signed [D_W-1:0] d,
  input  logic signed [Y_W-1:0] y,
  input  logic [SCALE_FRAC:0] s,
  output logic [PX_W-1:0] res
);

  logic signed [D_W-LO_W+SCALE_FRAC+1:0] prod_hi;
  logic [LO_W+SCALE_FRAC:0] prod_lo;
  logic signed [Y_W-1:0] y1;
  logic signed [SUM_W-1:0] total;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi <= $signed(d[D_W-1:LO_W]) * $signed({1'b0, s});
      prod_lo <= d[LO_W-1:0] * s;
      y1 <= y;
    end
  end

  assign total = (SUM_W'(prod_hi) <<< LO_W) + $signed(SUM_W'(prod_lo))
               + (SUM_W'(y1) <<< SCALE_FRAC)
               + (SUM_W'(1) <<< (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      res <= total[ROUND_SHIFT+PX_W-1:ROUND_SHIFT];
    end
  end

endmodule

FILE: hdl/gamut_fit_toward_neutral.sv
// Top level of the luminance preserving gamut fit toward neutral grey.
`timescale 1ns / 1ps
// The block takes one linear RGB pixel per transfer on the pix channel and
// returns one fitted pixel per transfer on the res channel, in order.
// Both channels use valid and stall; a transfer happens when valid is high
// and stall is low. The user must write the three luminance weights
// through the cfg port only while idle; the block does not enforce this.
// A pixel inside [0,1] passes unchanged; otherwise it is clipped or moved
// toward grey of equal luminance by the smallest fitting scale.
// Stages in order: luminance, classify, the pipelined divider (one
// quotient bit per stage), the minimum scale, the blend and the output
// register. Throughput is one pixel per cycle while the receiver does not
// stall; every stage holds one pixel.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pix_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits and loads the Rec.709 weights.
module gamut_fit_toward_neutral
  import gfn_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_stall,
  input  pixel_in_t pix,
  output logic res_valid,
  input  logic res_stall,
  output pixel_out_t res,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W_W-1:0] cfg_data
);

  localparam logic signed [PX_W-1:0] ONE = PX_W'(1) <<< FRAC_BITS;
  localparam logic signed [Y_W-1:0] ONE_Y = Y_W'(1) <<< (FRAC_BITS + 16);

  logic en;
  weights_t weights;
  logic luma_valid;
  pixel_in_t luma_pix;
  logic signed [Y_W-1:0] luma_y;

  logic signed [PX_W-1:0] chan [3];
  logic signed [V_W-1:0] v [3];
  logic signed [D_W-1:0] dc [3];
  logic over [3];
  logic under [3];
  logic [RW-1:0] num_c [3];
  logic [RW-1:0] den_c [3];
  logic in_range;
  side_t side_next;

  logic cls_valid;
  side_t cls_side;
  logic [RW-1:0] num_r [3];
  logic [RW-1:0] den_r [3];

  logic [DIV_STEPS-1:0] dv;
  side_t ds [DIV_STEPS];
  logic [SCALE_FRAC-1:0] quo [3];

  logic [SCALE_FRAC:0] s_next;
  logic min_valid;
  side_t min_side;
  logic [SCALE_FRAC:0] s_r;

  logic [1:0] bv;
  fit_path_t bpath [2];
  logic [2:0][PX_W-1:0] bclip [2];
  logic [PX_W-1:0] blend_res [3];

  assign en = !(res_valid && res_stall);
  assign pix_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights.red <= WR_RESET;
      weights.green <= WG_RESET;
      weights.blue <= WB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED:   weights.red <= cfg_data;
        REG_GREEN: weights.green <= cfg_data;
        REG_BLUE:  weights.blue <= cfg_data;
        default: ;
      endcase
    end
  end

  gfn_luma u_luma (
    .clk(clk),
    .rst(rst),
    .en(en),
    .weights(weights),
    .in_valid(pix_valid),
    .in_pix(pix),
    .out_valid(luma_valid),
    .out_pix(luma_pix),
    .y(luma_y)
  );

  assign chan[0] = luma_pix.red_in;
  assign chan[1] = luma_pix.green_in;
  assign chan[2] = luma_pix.blue_in;

  always_comb begin
    in_range = 1'b1;
    for (int c = 0; c < 3; c++) begin
      v[c] = {chan[c], 16'b0};
      dc[c] = D_W'(v[c]) - D_W'(luma_y);
      over[c] = chan[c] > ONE;
      under[c] = chan[c] < 0;
      if (over[c] || under[c]) in_range = 1'b0;
      num_c[c] = over[c] ? RW'(ONE_Y - luma_y) : RW'(luma_y);
      den_c[c] = over[c] ? RW'(dc[c]) : RW'(-dc[c]);
      side_next.clip[c] = under[c] ? '0 : chan[c];
      side_next.d[c] = dc[c];
      side_next.cand[c] = over[c] || under[c];
    end
    side_next.y = luma_y;
    priority if (in_range) side_next.path = PATH_KEEP;
    else if (luma_y <= 0) side_next.path = PATH_BLACK;
    else if (luma_y >= ONE_Y) side_next.path = PATH_WHITE;
    else side_next.path = PATH_SCALE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (en) begin
      cls_valid <= luma_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_side <= side_next;
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= num_c[c];
        den_r[c] <= den_c[c];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    gfn_div u_div (
      .clk(clk),
      .en(en),
      .num(num_r[c]),
      .den(den_r[c]),
      .quo(quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[DIV_STEPS-2:0], cls_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= cls_side;
      for (int k = 1; k < DIV_STEPS; k++) begin
        ds[k] <= ds[k-1];
      end
    end
  end

  always_comb begin
    s_next = (SCALE_FRAC + 1)'(1) << SCALE_FRAC;
    for (int c = 0; c < 3; c++) begin
      if (ds[DIV_STEPS-1].cand[c] && ({1'b0, quo[c]} < s_next)) begin
        s_next = {1'b0, quo[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid <= 1'b0;
    end else if (en) begin
      min_valid <= dv[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      min_side <= ds[DIV_STEPS-1];
      s_r <= s_next;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_blend
    gfn_blend u_blend (
      .clk(clk),
      .en(en),
      .d(min_side.d[c]),
      .y(min_side.y),
      .s(s_r),
      .res(blend_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      bv <= {bv[0], min_valid};
      res_valid <= bv[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bpath[0] <= min_side.path;
      bclip[0] <= min_side.clip;
      bpath[1] <= bpath[0];
      bclip[1] <= bclip[0];
      res.fit_path <= bpath[1];
      if (bpath[1] == PATH_SCALE) begin
        res.red_out <= blend_res[0];
        res.green_out <= blend_res[1];
        res.blue_out <= blend_res[2];
      end else begin
        res.red_out <= bclip[1][0];
        res.green_out <= bclip[1][1];
        res.blue_out <= bclip[1][2];
      end
    end
  end

endmodule

FILE: sim/gamut_fit_toward_neutral_tb.sv
// Self-checking testbench of the luminance preserving gamut fit toward neutral grey.
`timescale 1ns / 1ps
module gamut_fit_toward_neutral_tb;
  import gfn_pkg::*;

  typedef struct {
    pixel_in_t  px;
    bit         known;
    pixel_out_t want;
  } pixel_case_t;

  localparam int N_DIR = 16;
  localparam int N_PHASE = 5;
  localparam int PHASE_ITEMS = 320;
  localparam logic signed [31:0] PX_ONE = 32'sd65536;
  localparam logic signed [31:0] PX_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] PX_MAX = 32'sh7FFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  pixel_in_t pix;
  logic res_valid;
  logic res_stall;
  pixel_out_t res;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W_W-1:0] cfg_data;

  logic signed [W_W-1:0] wt_red;
  logic signed [W_W-1:0] wt_green;
  logic signed [W_W-1:0] wt_blue;
  pixel_out_t fitted_q[$];
  int errors;
  int sent;
  bit calm;
  bit held;
  int hold_left;

  pixel_case_t dir_cases [N_DIR] = '{
    '{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, PATH_KEEP}},
    '{'{PX_ONE, PX_ONE, PX_ONE}, 1'b1, '{PX_ONE, PX_ONE, PX_ONE, PATH_KEEP}},
    '{'{-32'sd1, -32'sd1, -32'sd1}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, PATH_BLACK}},
    '{'{PX_MIN, PX_MIN, PX_MIN}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, PATH_BLACK}},
    '{'{PX_MAX, PX_MAX, PX_MAX}, 1'b1, '{PX_MAX, PX_MAX, PX_MAX, PATH_WHITE}},
    '{'{32'sd131072, 32'sd131072, 32'sd131072}, 1'b1,
      '{32'sd131072, 32'sd131072, 32'sd131072, PATH_WHITE}},
    '{'{32'sd0, -32'sd4732, 32'sd46871}, 1'b1, '{32'sd0, 32'sd0, 32'sd46871, PATH_BLACK}},
    '{'{32'sd112407, 32'sd51603, PX_ONE}, 1'b1,
      '{32'sd112407, 32'sd51603, PX_ONE, PATH_WHITE}},
    '{'{32'sd131072, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{-32'sd32768, PX_ONE, PX_ONE}, 1'b0, '0},
    '{'{PX_ONE, -32'sd100, 32'sd32768}, 1'b0, '0},
    '{'{PX_MIN, 32'sd638450000, 32'sd0}, 1'b0, '0},
    '{'{32'sd200000, 32'sd30000, 32'sd10000}, 1'b0, '0},
    '{'{32'sd70000, -32'sd5000, PX_ONE}, 1'b0, '0},
    '{'{32'sd1, 32'sd65537, 32'sd0}, 1'b0, '0},
    '{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sd40000}, 1'b0, '0}
  };

  gamut_fit_toward_neutral dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("gamut_fit_toward_neutral_tb: errors");
    $finish;
  end

  // Rounds y + d*s to whole pixel units, ties upward.
  function automatic longint blend_luma(longint y, longint d, longint unsigned s);
    longint unsigned mag;
    longint unsigned prod;
    longint whole_y;
    longint rem_y;
    longint whole_p;
    longint rem_p;
    longint sum;
    mag = (d < 0) ? longint'(0) - d : d;
    prod = mag * s;
    whole_y = y / 65536;
    rem_y = (y & 64'hFFFF) << SCALE_FRAC;
    whole_p = longint'(prod >> ROUND_SHIFT);
    rem_p = longint'(prod & ((64'd1 << ROUND_SHIFT) - 1));
    if (d < 0) begin
      whole_p = -whole_p;
      rem_p = -rem_p;
    end
    sum = rem_y + rem_p + (64'sd1 <<< (ROUND_SHIFT - 1)) + (64'sd1 <<< ROUND_SHIFT);
    return whole_y + whole_p + (longint'(longint'(unsigned'(sum)) >> ROUND_SHIFT) - 1);
  endfunction

  function automatic pixel_out_t fit_pixel(pixel_in_t p);
    longint chan[3];
    longint outv[3];
    longint wt[3];
    longint y;
    longint num;
    longint den;
    longint q;
    longint scale;
    bit in_gamut;
    bit cand;
    fit_path_t path;
    pixel_out_t r;
    chan[0] = p.red_in;
    chan[1] = p.green_in;
    chan[2] = p.blue_in;
    wt[0] = wt_red;
    wt[1] = wt_green;
    wt[2] = wt_blue;
    in_gamut = 1'b1;
    y = 0;
    path = PATH_KEEP;
    for (int c = 0; c < 3; c++) begin
      outv[c] = chan[c];
      if (chan[c] < 0 || chan[c] > 65536) in_gamut = 1'b0;
    end
    if (!in_gamut) begin
      for (int c = 0; c < 3; c++) y += wt[c] * chan[c];
      if (y <= 0 || y >= (64'sd1 <<< 32)) begin
        path = (y <= 0) ? PATH_BLACK : PATH_WHITE;
        for (int c = 0; c < 3; c++) if (outv[c] < 0) outv[c] = 0;
      end else begin
        path = PATH_SCALE;
        scale = 64'sd1 <<< SCALE_FRAC;
        for (int c = 0; c < 3; c++) begin
          cand = 1'b1;
          num = 0;
          den = 0;
          if (chan[c] > 65536) begin
            num = (64'sd1 <<< 32) - y;
            den = chan[c] * 65536 - y;
          end else if (chan[c] < 0) begin
            num = y;
            den = y - chan[c] * 65536;
          end else begin
            cand = 1'b0;
          end
          if (cand && den != 0) begin
            q = (num <<< SCALE_FRAC) / den;
            if (q < scale) scale = q;
          end
        end
        for (int c = 0; c < 3; c++) outv[c] = blend_luma(y, chan[c] * 65536 - y, scale);
      end
    end
    r.red_out = outv[0][31:0];
    r.green_out = outv[1][31:0];
    r.blue_out = outv[2][31:0];
    r.fit_path = path;
    return r;
  endfunction

  function automatic logic [31:0] rand_channel();
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 65536);
      4, 5, 6: return 32'($urandom_range(0, 262144)) - 32'd65536;
      7: return $urandom;
      8: begin
        unique case ($urandom_range(0, 4))
          0: return 32'd0;
          1: return 32'd65536;
          2: return 32'd65535;
          3: return 32'd65537;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 1 << 22)) - 32'd2097152;
    endcase
  endfunction

  function automatic void queue_result(pixel_out_t r);
    fitted_q = {fitted_q, r};
  endfunction

  task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [W_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      REG_RED: wt_red = val;
      REG_GREEN: wt_green = val;
      REG_BLUE: wt_blue = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(pixel_in_t p, bit known, pixel_out_t want);
    while (!calm && $urandom_range(0, 99) < 26) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
    if (known) queue_result(want);
    else queue_result(fit_pixel(p));
    sent++;
    calm = (sent >= 600 && sent < 800);
  endtask

  task automatic drain();
    while (fitted_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    pixel_in_t p;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RED;
    cfg_data = '0;
    errors = 0;
    sent = 0;
    calm = 1'b0;
    wt_red = WR_RESET;
    wt_green = WG_RESET;
    wt_blue = WB_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++)
      send_pixel(dir_cases[i].px, dir_cases[i].known, dir_cases[i].want);
    for (int ph = 0; ph < N_PHASE; ph++) begin
      if (ph != 0) begin
        pix_valid <= 1'b0;
        @(posedge clk);
        drain();
        unique case (ph)
          1: begin
            write_weight(REG_RED, W_W'($urandom));
            write_weight(REG_GREEN, W_W'($urandom));
            write_weight(REG_BLUE, W_W'($urandom));
            write_weight(REG_UNUSED, W_W'($urandom));
          end
          2: begin
            write_weight(REG_RED, 18'h20000);
            write_weight(REG_GREEN, 18'h1FFFF);
            write_weight(REG_BLUE, 18'h20000);
          end
          3: begin
            write_weight(REG_RED, 18'h1FFFF);
            write_weight(REG_GREEN, 18'h1FFFF);
            write_weight(REG_BLUE, 18'h1FFFF);
          end
          default: begin
            write_weight(REG_RED, 18'd16384);
            write_weight(REG_GREEN, 18'd40000);
            write_weight(REG_BLUE, 18'd20000);
          end
        endcase
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        p.red_in = rand_channel();
        p.green_in = rand_channel();
        p.blue_in = rand_channel();
        send_pixel(p, 1'b0, '0);
      end
    end
    pix_valid <= 1'b0;
    @(posedge clk);
    drain();
    if (errors == 0) begin
      $display("gamut_fit_toward_neutral_tb: clean");
    end else begin
      $display("gamut_fit_toward_neutral_tb: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (fitted_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = fitted_q.pop_front();
          if (res.red_out !== want.red_out) begin
            $error("red_out expected %0d got %0d", want.red_out, res.red_out);
            errors++;
          end
          if (res.green_out !== want.green_out) begin
            $error("green_out expected %0d got %0d", want.green_out, res.green_out);
            errors++;
          end
          if (res.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d got %0d", want.blue_out, res.blue_out);
            errors++;
          end
          if (res.fit_path !== want.fit_path) begin
            $error("fit_path expected %0d got %0d", want.fit_path, res.fit_path);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      held = 1'b0;
      hold_left = 0;
    end else begin
      if (!held && sent >= 1000) begin
        held = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
    end
  end

endmodule
